/* src/stdf_pkg.sv */
package stdf_pkg;

    localparam int OCTET_W = 31;
    localparam int HELD_W  = 16;
    localparam int MODE_W  = 3;

    // Frame modes
    localparam logic [MODE_W-1:0] MODE_START = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NONTR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BODY  = 3'd5;

    localparam logic [OCTET_W-1:0] COUNT_MAX = {OCTET_W{1'b1}};
    localparam logic [HELD_W-1:0]  HELD_MAX  = {HELD_W{1'b1}};
    localparam logic [HELD_W-1:0]  MAX_LENGTH_RESET = 16'd1024;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Error kinds
    localparam logic ERR_DELIM = 1'b0;
    localparam logic ERR_COUNT = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       chunk_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       msg_end;
        logic       was_split;
        logic       framing_error;
        logic       error_kind;
    } t_out_item;

    typedef struct packed {
        logic [MODE_W-1:0]  frame_mode;
        logic [OCTET_W-1:0] octets_left;
        logic               count_overflow;
        logic [HELD_W-1:0]  held_length;
        logic               discarding;
    } t_state;

endpackage

/* src/stdf_step.sv */
module stdf_step
    import stdf_pkg::*;
(
    input  t_state            i_state,
    input  logic [HELD_W-1:0] i_max_length,
    input  t_in_item          i_item,
    output t_state            o_state,
    output t_out_item         o_result,
    output logic              o_result_valid
);

    always_comb begin
        t_state               nx;
        logic [7:0]           b;
        logic [7:0]           diff;
        logic [OCTET_W+3:0]   prod;
        logic                 has;
        logic                 fin;
        logic                 split;
        logic                 err;
        logic                 kind;

        nx    = i_state;
        b     = i_item.rx_byte;
        diff  = b - CH_ZERO;
        prod  = '0;
        has   = 1'b0;
        fin   = 1'b0;
        split = 1'b0;
        err   = 1'b0;
        kind  = ERR_DELIM;

        if (i_state.discarding) begin
            // drop until the end of the current read
            if (i_item.chunk_end) begin
                nx.discarding = 1'b0;
            end
        end else begin
            if (nx.frame_mode == MODE_START) begin
                if (b > CH_ZERO && b <= CH_NINE) begin
                    nx.octets_left    = '0;
                    nx.count_overflow = 1'b0;
                    nx.frame_mode     = MODE_COUNT;
                end else begin
                    nx.frame_mode = MODE_NONTR;
                end
            end

            case (nx.frame_mode)
                MODE_COUNT: begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        // count * 10 + digit as two shifts and two adds
                        prod = ({4'b0, nx.octets_left} << 3) + ({4'b0, nx.octets_left} << 1)
                             + {{(OCTET_W){1'b0}}, diff[3:0]};
                        if (|prod[OCTET_W+3:OCTET_W]) begin
                            nx.count_overflow = 1'b1;
                            nx.octets_left    = COUNT_MAX;
                        end else begin
                            nx.octets_left = prod[OCTET_W-1:0];
                        end
                    end else if (b != CH_SPACE) begin
                        err  = 1'b1;
                        kind = ERR_DELIM;
                    end else if (nx.octets_left == '0 || nx.count_overflow) begin
                        err  = 1'b1;
                        kind = ERR_COUNT;
                    end else begin
                        nx.frame_mode = MODE_BODY;
                    end
                end
                MODE_NONTR: begin
                    if (b == CH_LF || b == CH_NUL) begin
                        fin            = 1'b1;
                        nx.held_length = '0;
                        nx.frame_mode  = MODE_START;
                    end else begin
                        has = 1'b1;
                        if (nx.held_length != HELD_MAX) begin
                            nx.held_length = nx.held_length + 1'b1;
                        end
                    end
                end
                MODE_BODY: begin
                    has = 1'b1;
                    if (nx.held_length != HELD_MAX) begin
                        nx.held_length = nx.held_length + 1'b1;
                    end
                    nx.octets_left = nx.octets_left - 1'b1;
                    if (nx.octets_left == '0) begin
                        fin            = 1'b1;
                        nx.held_length = '0;
                        nx.frame_mode  = MODE_START;
                    end
                end
                default: begin
                    nx.frame_mode = MODE_START;
                end
            endcase

            if (err) begin
                if (!i_item.chunk_end) begin
                    nx.discarding = 1'b1;
                end
            end else if (i_max_length != '0 && nx.held_length == i_max_length) begin
                fin            = 1'b1;
                split          = 1'b1;
                nx.held_length = '0;
            end
        end

        o_state                = nx;
        o_result.msg_byte      = has ? b : 8'h00;
        o_result.has_byte      = has;
        o_result.msg_end       = fin;
        o_result.was_split     = split;
        o_result.framing_error = err;
        o_result.error_kind    = err ? kind : ERR_DELIM;
        o_result_valid         = has | fin | err;
    end

endmodule

/* src/syslog_tcp_deframer_top.sv */
// Syslog-over-TCP deframer: takes one received stream byte per item and
// emits message bytes as they arrive, with an end flag on the last one.
// A frame opening with '1'..'9' is octet-counted (decimal length, space,
// then that many bytes); any other opening byte starts newline/NUL
// delimited framing, where the delimiter is dropped and an empty message
// still gives an end result. A message that reaches max_length is ended
// there with was_split set (max_length 0 disables splitting). A bad
// delimiter or a zero or overflowing count gives one error result, and the
// rest of the read (up to the byte with chunk_end) is dropped silently.
// Throughput is one item per cycle unless the output stalls: the frame
// state is updated in the cycle an item is accepted, the widest path being
// the count * 10 + digit add, and the result sits in one output register.
// Items that produce no result (count digits, dropped bytes) emit nothing.
// Write max_length through the config port only while the block is idle.
module syslog_tcp_deframer_top
    import stdf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    // max_length register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [HELD_W-1:0] i_cfg_data
);

    t_state            r_state;
    t_state            n_state;
    logic [HELD_W-1:0] r_max_length;
    t_out_item         r_out;
    t_out_item         n_out;
    logic              r_out_valid;
    logic              n_result_valid;
    logic              in_acc;

    // Accept a new item whenever the result register is empty or drains now.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    stdf_step u_step (
        .i_state        (r_state),
        .i_max_length   (r_max_length),
        .i_item         (i_in_data),
        .o_state        (n_state),
        .o_result       (n_out),
        .o_result_valid (n_result_valid)
    );

    // Frame state and the config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_max_length <= MAX_LENGTH_RESET;
        end else begin
            if (in_acc) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_max_length <= i_cfg_data;
            end
        end
    end

    // Result register: load on an accepted item with a result, clear on drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && n_result_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_result_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.framing_error)
            |-> (!o_out_data.has_byte && !o_out_data.msg_end))
        else $error("framing error result carries a byte or an end");

    a_split_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.was_split) |-> o_out_data.msg_end)
        else $error("split without message end");

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_state.discarding && !o_out_valid) |=> !o_out_valid)
        else $error("dropped item produced a result");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count_overflow |-> (r_state.octets_left == COUNT_MAX))
        else $error("count overflow without saturated count");
`endif

endmodule
